// File: hw/rtl/mes_pkg.sv
// shared constants, types and helper functions of the mandelbrot escape shader
package mes_pkg;

  localparam int COORD_BITS = 12;
  localparam int MAX_ITER   = 18;
  localparam int FRAC_BITS  = 28;

  localparam int PIX_W   = 12;
  localparam int CFG_W   = 32;
  localparam int SHADE_W = 8;
  localparam int COUNT_W = 5;
  localparam int IDX_W   = 2;

  localparam int SHADE_STEP = 15;
  localparam int SHADE_MAX  = 255;

  // pixel bits that take part in the mapping
  localparam int COORD_USE = (COORD_BITS < PIX_W) ? COORD_BITS : PIX_W;
  // product of unsigned pixel index and signed step, and c with origin added
  localparam int CP_W = COORD_USE + 1 + CFG_W;
  localparam int CS_W = CP_W + 1;
  // z always lies within +-8 once c passed the range check
  localparam int Z_W    = FRAC_BITS + 4;
  localparam int P_W    = 2 * Z_W;
  localparam int ITER_W = $clog2(MAX_ITER + 1);

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [CFG_W-1:0] RE_ORIGIN_RST = 32'hE000_0000;
  localparam logic [CFG_W-1:0] RE_STEP_RST   = 32'd589505;
  localparam logic [CFG_W-1:0] IM_ORIGIN_RST = 32'hE800_0000;
  localparam logic [CFG_W-1:0] IM_STEP_RST   = 32'd1048576;

  typedef enum logic [IDX_W-1:0] {
    REG_RE_ORIGIN,
    REG_RE_STEP,
    REG_IM_ORIGIN,
    REG_IM_STEP
  } mes_reg_e;

  typedef enum logic [1:0] {
    B_IDLE,
    B_MUL,
    B_UPD,
    B_FIN
  } mes_state_e;

  typedef struct packed {
    logic signed [CFG_W-1:0] re_origin;
    logic signed [CFG_W-1:0] re_step;
    logic signed [CFG_W-1:0] im_origin;
    logic signed [CFG_W-1:0] im_step;
  } mes_cfg_t;

  // one classified point handed from front to back
  typedef struct packed {
    logic                  far;
    logic signed [Z_W-1:0] cr;
    logic signed [Z_W-1:0] ci;
  } mes_item_t;

  function automatic logic [SHADE_W-1:0] shade_of(logic [ITER_W-1:0] n);
    logic [ITER_W+7:0] s;
    s = (ITER_W + 8)'(n) * (ITER_W + 8)'(SHADE_STEP);
    return (s > (ITER_W + 8)'(SHADE_MAX)) ? SHADE_W'(SHADE_MAX) : s[SHADE_W-1:0];
  endfunction

  function automatic logic [COUNT_W-1:0] count_field(logic [ITER_W-1:0] n);
    logic [ITER_W+COUNT_W-1:0] w;
    w = (ITER_W + COUNT_W)'(n);
    return w[COUNT_W-1:0];
  endfunction

endpackage

// File: hw/rtl/mes_front.sv
// front end: maps a pixel to c and flags points that lie far outside the set
module mes_front import mes_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  mes_cfg_t             cfg_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [PIX_W-1:0]     pixel_x_i,
  input  logic [PIX_W-1:0]     pixel_y_i,
  input  logic                 q_full_i,
  output logic                 push_o,
  output mes_item_t            item_o
);

  logic                   s1_valid_q, s1_valid_d;
  logic signed [CP_W-1:0] prod_re_q, prod_re_d;
  logic signed [CP_W-1:0] prod_im_q, prod_im_d;
  logic signed [CP_W-1:0] px_ext, py_ext, rs_ext, is_ext;
  logic signed [CS_W-1:0] sum_re, sum_im;
  logic                   accept;
  logic                   fit_re, fit_im;

  assign in_stall_o = s1_valid_q && q_full_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign push_o     = s1_valid_q && !q_full_i;

  assign px_ext = CP_W'({1'b0, pixel_x_i[COORD_USE-1:0]});
  assign py_ext = CP_W'({1'b0, pixel_y_i[COORD_USE-1:0]});
  assign rs_ext = {{(CP_W - CFG_W){cfg_i.re_step[CFG_W-1]}}, cfg_i.re_step};
  assign is_ext = {{(CP_W - CFG_W){cfg_i.im_step[CFG_W-1]}}, cfg_i.im_step};

  always_comb begin
    prod_re_d  = prod_re_q;
    prod_im_d  = prod_im_q;
    s1_valid_d = s1_valid_q;
    if (accept) begin
      prod_re_d  = px_ext * rs_ext;
      prod_im_d  = py_ext * is_ext;
      s1_valid_d = 1'b1;
    end else if (push_o) begin
      s1_valid_d = 1'b0;
    end
  end

  assign sum_re = {prod_re_q[CP_W-1], prod_re_q} +
                  {{(CS_W - CFG_W){cfg_i.re_origin[CFG_W-1]}}, cfg_i.re_origin};
  assign sum_im = {prod_im_q[CP_W-1], prod_im_q} +
                  {{(CS_W - CFG_W){cfg_i.im_origin[CFG_W-1]}}, cfg_i.im_origin};

  // a part that does not fit in z's width is beyond radius 2 for sure
  assign fit_re = (&sum_re[CS_W-1:Z_W-1]) || !(|sum_re[CS_W-1:Z_W-1]);
  assign fit_im = (&sum_im[CS_W-1:Z_W-1]) || !(|sum_im[CS_W-1:Z_W-1]);

  assign item_o.far = !(fit_re && fit_im);
  assign item_o.cr  = sum_re[Z_W-1:0];
  assign item_o.ci  = sum_im[Z_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_re_q <= prod_re_d;
    prod_im_q <= prod_im_d;
  end

endmodule

// File: hw/rtl/mes_queue.sv
// short fifo of classified points between front and back
module mes_queue import mes_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  mes_item_t item_i,
  output logic      full_o,
  output logic      valid_o,
  output mes_item_t item_o,
  input  logic      pop_i
);

  mes_item_t           mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_q, wr_d, rd_q, rd_d;
  logic [QCNT_W-1:0]   cnt_q, cnt_d;
  logic                do_push, do_pop;

  assign full_o  = (cnt_q == QCNT_W'(QUEUE_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign item_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= item_i;
    end
  end

endmodule

// File: hw/rtl/mes_back.sv
// back end: escape-time iteration with one set of squarers and an output register
module mes_back import mes_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 q_valid_i,
  input  mes_item_t            q_item_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [SHADE_W-1:0]   shade_o,
  output logic [COUNT_W-1:0]   iter_count_o
);

  localparam logic [P_W:0] ESC_LIMIT = (P_W + 1)'(1) << (2 * FRAC_BITS + 2);

  mes_state_e             state_q, state_d;
  logic signed [Z_W-1:0]  cr_q, cr_d, ci_q, ci_d, zr_q, zr_d, zi_q, zi_d;
  logic [ITER_W-1:0]      iter_q, iter_d;
  logic signed [P_W-1:0]  rr_q, ii_q, ri_q, rr_d, ii_d, ri_d;
  logic signed [P_W-1:0]  zr_ext, zi_ext;
  logic signed [P_W:0]    mag_sum, diff, twice, diff_sh, twice_sh;
  logic                   escape;
  logic                   out_valid_q, out_valid_d, load;
  logic [SHADE_W-1:0]     shade_q, shade_d;
  logic [COUNT_W-1:0]     count_q, count_d;

  assign zr_ext = {{(P_W - Z_W){zr_q[Z_W-1]}}, zr_q};
  assign zi_ext = {{(P_W - Z_W){zi_q[Z_W-1]}}, zi_q};

  // squares are never negative, so the sum compares as unsigned
  assign mag_sum  = {rr_q[P_W-1], rr_q} + {ii_q[P_W-1], ii_q};
  assign escape   = $unsigned(mag_sum) > ESC_LIMIT;
  assign diff     = {rr_q[P_W-1], rr_q} - {ii_q[P_W-1], ii_q};
  assign twice    = {ri_q, 1'b0};
  assign diff_sh  = diff >>> FRAC_BITS;
  assign twice_sh = twice >>> FRAC_BITS;

  always_comb begin
    state_d = state_q;
    cr_d    = cr_q;
    ci_d    = ci_q;
    zr_d    = zr_q;
    zi_d    = zi_q;
    iter_d  = iter_q;
    rr_d    = rr_q;
    ii_d    = ii_q;
    ri_d    = ri_q;
    pop_o   = 1'b0;
    load    = 1'b0;
    unique case (state_q)
      B_IDLE: begin
        if (q_valid_i) begin
          pop_o   = 1'b1;
          cr_d    = q_item_i.cr;
          ci_d    = q_item_i.ci;
          zr_d    = q_item_i.cr;
          zi_d    = q_item_i.ci;
          iter_d  = '0;
          state_d = q_item_i.far ? B_FIN : B_MUL;
        end
      end
      B_MUL: begin
        rr_d    = zr_ext * zr_ext;
        ii_d    = zi_ext * zi_ext;
        ri_d    = zr_ext * zi_ext;
        state_d = B_UPD;
      end
      B_UPD: begin
        if (escape) begin
          state_d = B_FIN;
        end else begin
          zr_d   = diff_sh[Z_W-1:0] + cr_q;
          zi_d   = twice_sh[Z_W-1:0] + ci_q;
          iter_d = iter_q + 1'b1;
          state_d = (iter_q == ITER_W'(MAX_ITER - 1)) ? B_FIN : B_MUL;
        end
      end
      B_FIN: begin
        if (!out_valid_q || !out_stall_i) begin
          load    = 1'b1;
          state_d = B_IDLE;
        end
      end
      default: state_d = B_IDLE;
    endcase
  end

  always_comb begin
    shade_d     = shade_q;
    count_d     = count_q;
    out_valid_d = out_valid_q;
    if (load) begin
      shade_d     = shade_of(iter_q);
      count_d     = count_field(iter_q);
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign shade_o      = shade_q;
  assign iter_count_o = count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      out_valid_q <= 1'b0;
      iter_q      <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      iter_q      <= iter_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cr_q    <= cr_d;
    ci_q    <= ci_d;
    zr_q    <= zr_d;
    zi_q    <= zi_d;
    rr_q    <= rr_d;
    ii_q    <= ii_d;
    ri_q    <= ri_d;
    shade_q <= shade_d;
    count_q <= count_d;
  end

  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> state_q == B_IDLE)
    else $error("queue popped while a point is in flight");

  a_upd_after_mul: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == B_UPD |-> $past(state_q) == B_MUL)
    else $error("update without fresh products");

  a_iter_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    iter_q <= ITER_W'(MAX_ITER))
    else $error("iteration count beyond limit");

  a_load_frees: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> out_valid_q && state_q == B_IDLE)
    else $error("result load did not present a word");

endmodule

// File: hw/rtl/mandelbrot_escape_shader_core.sv
// top level of the mandelbrot escape shader: view registers, front, queue and back
//
//   channel  direction  handshake                 payload
//   cfg      in         cfg_we_i                  cfg_idx_i, cfg_wdata_i
//   pixel    in         in_valid_i / in_stall_o   pixel_x_i, pixel_y_i
//   result   out        out_valid_o / out_stall_i shade_o, iter_count_o
//
// each iteration of the back end runs the squarers, then the escape test and
// update; a point whose c lies far outside the radius skips the iteration.
// the front maps pixels to c and keeps working while the back iterates.
// reset restores the default view registers and empties front, queue and back.
// a stalled result waits in the output register; the back then holds its point.
module mandelbrot_escape_shader_core import mes_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [IDX_W-1:0]     cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [PIX_W-1:0]     pixel_x_i,
  input  logic [PIX_W-1:0]     pixel_y_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [SHADE_W-1:0]   shade_o,
  output logic [COUNT_W-1:0]   iter_count_o
);

  mes_cfg_t  cfg_q;
  mes_item_t push_item, q_item;
  logic      push, q_full, q_valid, pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.re_origin <= RE_ORIGIN_RST;
      cfg_q.re_step   <= RE_STEP_RST;
      cfg_q.im_origin <= IM_ORIGIN_RST;
      cfg_q.im_step   <= IM_STEP_RST;
    end else if (cfg_we_i) begin
      unique case (mes_reg_e'(cfg_idx_i))
        REG_RE_ORIGIN: cfg_q.re_origin <= cfg_wdata_i;
        REG_RE_STEP:   cfg_q.re_step   <= cfg_wdata_i;
        REG_IM_ORIGIN: cfg_q.im_origin <= cfg_wdata_i;
        REG_IM_STEP:   cfg_q.im_step   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  mes_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .pixel_x_i  (pixel_x_i),
    .pixel_y_i  (pixel_y_i),
    .q_full_i   (q_full),
    .push_o     (push),
    .item_o     (push_item)
  );

  mes_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (push_item),
    .full_o  (q_full),
    .valid_o (q_valid),
    .item_o  (q_item),
    .pop_i   (pop)
  );

  mes_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_valid_i    (q_valid),
    .q_item_i     (q_item),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .shade_o      (shade_o),
    .iter_count_o (iter_count_o)
  );

endmodule
